### hw/rtl/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types and constants of the multi-reader frame ring.
// ----------------------------------------------------------------------------
package frr_pkg;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int STAT_W   = 3;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int HDR_BYTES = 4;
    localparam int CAP_MIN  = 16;
    localparam int CAP_RESET = 4096;
    localparam int RCNT_RESET = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE  = 2'd0,
        FN_READ   = 2'd1,
        FN_ATTACH = 2'd2,
        FN_DETACH = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NO_SPACE = 3'd1,
        STAT_INACTIVE = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_BAD_LEN  = 3'd4,
        STAT_IGNORED  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_CAPACITY = 2'd0,
        REG_READER_COUNT  = 2'd1,
        REG_SPARE2        = 2'd2,
        REG_SPARE3        = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ALU_ADVANCE = 1'b0,
        ALU_USED    = 1'b1
    } alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_W_SCAN,
        S_W_ALIGN1,
        S_W_ALIGN2,
        S_W_CHECK,
        S_W_HDR,
        S_W_POS,
        S_W_DATA,
        S_R_USED,
        S_R_HADDR,
        S_R_HDATA,
        S_R_HCHECK,
        S_R_CUR4,
        S_R_BADDR,
        S_R_BDATA,
        S_RESP
    } state_t;

endpackage

### hw/rtl/frr_chan_if.sv
// ----------------------------------------------------------------------------
// frr_chan_if
// Valid/ready channels of the frame ring: command, response, configuration.
// ----------------------------------------------------------------------------
interface frr_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [frr_pkg::FUNC_W-1:0]  func;
    logic [frr_pkg::ID_W-1:0]    reader_id;
    logic [frr_pkg::BYTE_W-1:0]  write_byte;
    logic                        frame_start;
    logic [frr_pkg::LEN_W-1:0]   frame_bytes;

    modport source (output valid, func, reader_id, write_byte, frame_start, frame_bytes,
                    input ready);
    modport sink   (input valid, func, reader_id, write_byte, frame_start, frame_bytes,
                    output ready);
endinterface

interface frr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [frr_pkg::STAT_W-1:0]  status;
    logic [frr_pkg::BYTE_W-1:0]  read_byte;
    logic                        frame_end;
    logic [frr_pkg::LEN_W-1:0]   delivered_length;

    modport source (output valid, status, read_byte, frame_end, delivered_length,
                    input ready);
    modport sink   (input valid, status, read_byte, frame_end, delivered_length,
                    output ready);
endinterface

interface frr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [frr_pkg::CFG_IDX_W-1:0] index;
    logic [frr_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/frr_alu.sv
// ----------------------------------------------------------------------------
// frr_alu
// Shared ring-position unit: modular advance and used-byte distance.
// ----------------------------------------------------------------------------
module frr_alu #(
    parameter int PW = 12
) (
    input  frr_pkg::alu_op_t op,
    input  logic [PW-1:0]    a,
    input  logic [PW-1:0]    b,
    input  logic [PW:0]      cap,
    output logic [PW-1:0]    y
);

    logic [PW:0] sum;
    logic [PW:0] diff;

    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b};
        diff = {1'b0, a} - {1'b0, b} + ((a < b) ? cap : '0);
        case (op)
            frr_pkg::ALU_ADVANCE:
            begin
                if (sum >= cap)
                begin
                    y = PW'(sum - cap);
                end
                else
                begin
                    y = sum[PW-1:0];
                end
            end
            frr_pkg::ALU_USED: y = diff[PW-1:0];
            default: y = '0;
        endcase
    end

endmodule

### hw/rtl/frr_ring_mem.sv
// ----------------------------------------------------------------------------
// frr_ring_mem
// Byte store of the ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module frr_ring_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [frr_pkg::BYTE_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [frr_pkg::BYTE_W-1:0]  rdata
);

    logic [frr_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/multi_reader_frame_ring_unit.sv
// Accept to response: attach/detach and status decided at dispatch answer directly; a write
// payload byte is written; a frame start runs the tail scan, alignment multiply, 4 header
// writes and the byte write; a read inside a frame reads a byte; a read that opens a frame
// first does 4 header reads. One transaction at a time; the next is accepted after the
// response is registered, or later while rsp is held off. Config is taken only when idle.
// Reset: readers inactive, positions zero, default capacity and reader count.
// ----------------------------------------------------------------------------
// multi_reader_frame_ring_unit
// One-writer, multi-reader framed byte ring with per-reader tails.
// ----------------------------------------------------------------------------
module multi_reader_frame_ring_unit #(
    parameter int RING_BYTES  = 4096,
    parameter int MAX_READERS = 8,
    parameter int ALIGN_BYTES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    frr_cmd_if.sink        cmd,
    frr_rsp_if.source      rsp,
    frr_cfg_if.sink        cfg
);

    localparam int PW   = $clog2(RING_BYTES);
    localparam int CW   = PW + 1;
    localparam int IW   = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int RW   = $clog2(MAX_READERS + 1);
    localparam int YW   = frr_pkg::LEN_W + 1;
    localparam int ASH  = YW + 7;
    localparam int AMUL = (2**ASH + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PRW  = ASH + YW;
    localparam int NW   = YW + 7;
    localparam int CAP_RST  = (frr_pkg::CAP_RESET > RING_BYTES) ? RING_BYTES
                                                                 : frr_pkg::CAP_RESET;
    localparam int RCNT_RST = (frr_pkg::RCNT_RESET > MAX_READERS) ? MAX_READERS
                                                                   : frr_pkg::RCNT_RESET;

    frr_pkg::state_t state_reg, state_next;

    // control / position state
    logic [PW-1:0]            head_reg;
    logic [PW-1:0]            wpos_reg;
    logic [frr_pkg::LEN_W-1:0] wleft_reg;
    logic                     wdrop_reg;
    logic [PW-1:0]            worst_reg;
    logic [RW-1:0]            scan_reg;
    logic [1:0]               k_reg;
    logic [IW-1:0]            idx_reg;
    logic [CW-1:0]            cap_reg;
    logic [RW-1:0]            rcnt_reg;
    logic                     ovalid_reg;

    logic [PW-1:0]             tail_reg   [MAX_READERS];
    logic [PW-1:0]             cursor_reg [MAX_READERS];
    logic [frr_pkg::LEN_W-1:0] rleft_reg  [MAX_READERS];
    logic [frr_pkg::LEN_W-1:0] rlen_reg   [MAX_READERS];
    logic [MAX_READERS-1:0]    active_reg;

    // payload
    frr_pkg::func_t            func_reg;
    logic [frr_pkg::ID_W-1:0]  id_reg;
    logic [frr_pkg::BYTE_W-1:0] wb_reg;
    logic                      start_reg;
    logic [frr_pkg::LEN_W-1:0] flen_reg;
    logic [YW-1:0]             y_reg;
    logic [PRW-1:0]            prod_reg;
    logic [NW-1:0]             need_reg;
    logic [31:0]               hl_reg;
    logic [PW-1:0]             ulen_reg;
    frr_pkg::status_t          st_reg;
    logic [frr_pkg::BYTE_W-1:0] rb_reg;
    logic                      fe_reg;
    logic [frr_pkg::LEN_W-1:0] dl_reg;
    frr_pkg::status_t          ost_reg;
    logic [frr_pkg::BYTE_W-1:0] orb_reg;
    logic                      ofe_reg;
    logic [frr_pkg::LEN_W-1:0] odl_reg;

    // shared unit and memory hookup
    frr_pkg::alu_op_t          alu_op;
    logic [PW-1:0]             alu_a, alu_b, alu_y;
    logic                      mem_we;
    logic [PW-1:0]             mem_waddr, mem_raddr;
    logic [frr_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

    logic                      rd_out;
    logic                      scan_last;
    logic [CW-1:0]             free_space;
    logic                      drop_now;
    logic                      hdr_bad;
    logic                      hdr_short;
    logic                      resp_load;
    logic [31:0]               hdr_word;
    logic [RW-1:0]             cfg_rcnt;
    logic [CW-1:0]             cfg_cap;

    frr_alu #(.PW(PW)) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .cap (cap_reg),
        .y   (alu_y)
    );

    frr_ring_mem #(.DEPTH(RING_BYTES), .AW(PW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        rd_out     = 32'(id_reg) >= 32'(rcnt_reg);
        scan_last  = (RW'(scan_reg + 1'b1) == rcnt_reg);
        free_space = cap_reg - CW'(1) - CW'(worst_reg);
        drop_now   = 32'(need_reg) > 32'(free_space);
        hdr_bad    = (hl_reg == 32'd0) || (hl_reg > 32'(cap_reg));
        hdr_short  = (32'(ulen_reg) - 32'(frr_pkg::HDR_BYTES)) < hl_reg;
        resp_load  = !ovalid_reg || rsp.ready;
        hdr_word   = 32'(flen_reg);
        // clamp config writes into their legal ranges
        if (32'(cfg.data) < 32'(frr_pkg::CAP_MIN))
        begin
            cfg_cap = CW'(frr_pkg::CAP_MIN);
        end
        else if (32'(cfg.data) > 32'(RING_BYTES))
        begin
            cfg_cap = CW'(RING_BYTES);
        end
        else
        begin
            cfg_cap = CW'(cfg.data);
        end
        if (cfg.data[frr_pkg::CNT_W-1:0] == '0)
        begin
            cfg_rcnt = RW'(1);
        end
        else if (32'(cfg.data[frr_pkg::CNT_W-1:0]) > 32'(MAX_READERS))
        begin
            cfg_rcnt = RW'(MAX_READERS);
        end
        else
        begin
            cfg_rcnt = RW'(cfg.data[frr_pkg::CNT_W-1:0]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frr_pkg::S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    state_next = frr_pkg::S_DISPATCH;
                end
            end
            frr_pkg::S_DISPATCH:
            begin
                if (func_reg == frr_pkg::FN_WRITE)
                begin
                    if (start_reg)
                    begin
                        if (flen_reg == '0 || 32'(flen_reg) > 32'(cap_reg))
                        begin
                            state_next = frr_pkg::S_RESP;
                        end
                        else
                        begin
                            state_next = frr_pkg::S_W_SCAN;
                        end
                    end
                    else if (wleft_reg == '0 || wdrop_reg)
                    begin
                        state_next = frr_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = frr_pkg::S_W_DATA;
                    end
                end
                else if (rd_out)
                begin
                    state_next = frr_pkg::S_RESP;
                end
                else if (func_reg == frr_pkg::FN_READ)
                begin
                    if (!active_reg[idx_reg])
                    begin
                        state_next = frr_pkg::S_RESP;
                    end
                    else if (rleft_reg[idx_reg] != '0)
                    begin
                        state_next = frr_pkg::S_R_BADDR;
                    end
                    else
                    begin
                        state_next = frr_pkg::S_R_USED;
                    end
                end
                else
                begin
                    state_next = frr_pkg::S_RESP;
                end
            end
            frr_pkg::S_W_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = frr_pkg::S_W_ALIGN1;
                end
            end
            frr_pkg::S_W_ALIGN1: state_next = frr_pkg::S_W_ALIGN2;
            frr_pkg::S_W_ALIGN2: state_next = frr_pkg::S_W_CHECK;
            frr_pkg::S_W_CHECK:
            begin
                state_next = drop_now ? frr_pkg::S_RESP : frr_pkg::S_W_HDR;
            end
            frr_pkg::S_W_HDR:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = frr_pkg::S_W_POS;
                end
            end
            frr_pkg::S_W_POS:  state_next = frr_pkg::S_W_DATA;
            frr_pkg::S_W_DATA: state_next = frr_pkg::S_RESP;
            frr_pkg::S_R_USED:
            begin
                if (32'(alu_y) < 32'(frr_pkg::HDR_BYTES))
                begin
                    state_next = frr_pkg::S_RESP;
                end
                else
                begin
                    state_next = frr_pkg::S_R_HADDR;
                end
            end
            frr_pkg::S_R_HADDR: state_next = frr_pkg::S_R_HDATA;
            frr_pkg::S_R_HDATA:
            begin
                state_next = (k_reg == 2'd3) ? frr_pkg::S_R_HCHECK : frr_pkg::S_R_HADDR;
            end
            frr_pkg::S_R_HCHECK:
            begin
                state_next = (hdr_bad || hdr_short) ? frr_pkg::S_RESP : frr_pkg::S_R_CUR4;
            end
            frr_pkg::S_R_CUR4:  state_next = frr_pkg::S_R_BADDR;
            frr_pkg::S_R_BADDR: state_next = frr_pkg::S_R_BDATA;
            frr_pkg::S_R_BDATA: state_next = frr_pkg::S_RESP;
            frr_pkg::S_RESP:
            begin
                if (resp_load)
                begin
                    state_next = frr_pkg::S_IDLE;
                end
            end
            default: state_next = frr_pkg::S_IDLE;
        endcase
    end

    // shared unit and memory port selection
    always_comb
    begin
        alu_op    = frr_pkg::ALU_ADVANCE;
        alu_a     = '0;
        alu_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = alu_y;
        mem_wdata = wb_reg;
        mem_raddr = cursor_reg[idx_reg];
        case (state_reg)
            frr_pkg::S_W_SCAN:
            begin
                alu_op = frr_pkg::ALU_USED;
                alu_a  = head_reg;
                alu_b  = tail_reg[idx_reg];
            end
            frr_pkg::S_W_HDR:
            begin
                alu_a     = head_reg;
                alu_b     = PW'(k_reg);
                mem_we    = 1'b1;
                mem_wdata = hdr_word[8*k_reg +: 8];
            end
            frr_pkg::S_W_POS:
            begin
                alu_a = head_reg;
                alu_b = PW'(frr_pkg::HDR_BYTES);
            end
            frr_pkg::S_W_DATA:
            begin
                alu_a     = wpos_reg;
                alu_b     = PW'(1);
                mem_we    = 1'b1;
                mem_waddr = wpos_reg;
            end
            frr_pkg::S_R_USED:
            begin
                alu_op = frr_pkg::ALU_USED;
                alu_a  = head_reg;
                alu_b  = cursor_reg[idx_reg];
            end
            frr_pkg::S_R_HADDR:
            begin
                alu_a     = cursor_reg[idx_reg];
                alu_b     = PW'(k_reg);
                mem_raddr = alu_y;
            end
            frr_pkg::S_R_CUR4:
            begin
                alu_a = cursor_reg[idx_reg];
                alu_b = PW'(frr_pkg::HDR_BYTES);
            end
            frr_pkg::S_R_BDATA:
            begin
                alu_a = cursor_reg[idx_reg];
                alu_b = PW'(1);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // config has priority over a new command while idle
    assign cmd.ready            = (state_reg == frr_pkg::S_IDLE) && !cfg.valid;
    assign cfg.ready            = (state_reg == frr_pkg::S_IDLE);
    assign rsp.valid            = ovalid_reg;
    assign rsp.status           = ost_reg;
    assign rsp.read_byte        = orb_reg;
    assign rsp.frame_end        = ofe_reg;
    assign rsp.delivered_length = odl_reg;

    // control and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= frr_pkg::S_IDLE;
            head_reg   <= '0;
            wpos_reg   <= '0;
            wleft_reg  <= '0;
            wdrop_reg  <= 1'b0;
            worst_reg  <= '0;
            scan_reg   <= '0;
            k_reg      <= '0;
            idx_reg    <= '0;
            cap_reg    <= CW'(CAP_RST);
            rcnt_reg   <= RW'(RCNT_RST);
            ovalid_reg <= 1'b0;
            active_reg <= '0;
            for (int i = 0; i < MAX_READERS; i++)
            begin
                tail_reg[i]   <= '0;
                cursor_reg[i] <= '0;
                rleft_reg[i]  <= '0;
                rlen_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == frr_pkg::S_RESP && resp_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ovalid_reg <= 1'b0;
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    frr_pkg::REG_RING_CAPACITY:
                    begin
                        cap_reg   <= cfg_cap;
                        head_reg  <= '0;
                        wpos_reg  <= '0;
                        wleft_reg <= '0;
                        wdrop_reg <= 1'b0;
                        for (int i = 0; i < MAX_READERS; i++)
                        begin
                            tail_reg[i]   <= '0;
                            cursor_reg[i] <= '0;
                            rleft_reg[i]  <= '0;
                            rlen_reg[i]   <= '0;
                        end
                    end
                    frr_pkg::REG_READER_COUNT:
                    begin
                        rcnt_reg <= cfg_rcnt;
                        for (int i = 0; i < MAX_READERS; i++)
                        begin
                            if (32'(i) >= 32'(cfg_rcnt))
                            begin
                                active_reg[i] <= 1'b0;
                                rleft_reg[i]  <= '0;
                            end
                        end
                    end
                    default:
                    begin
                        rcnt_reg <= rcnt_reg;
                    end
                endcase
            end
            else
            begin
                case (state_reg)
                    frr_pkg::S_IDLE:
                    begin
                        idx_reg <= IW'(cmd.reader_id);
                    end
                    frr_pkg::S_DISPATCH:
                    begin
                        if (func_reg == frr_pkg::FN_WRITE)
                        begin
                            if (start_reg)
                            begin
                                wleft_reg <= '0;
                                wdrop_reg <= 1'b0;
                                worst_reg <= '0;
                                scan_reg  <= '0;
                                idx_reg   <= '0;
                                if (flen_reg != '0 && 32'(flen_reg) > 32'(cap_reg))
                                begin
                                    wleft_reg <= flen_reg - 1'b1;
                                    wdrop_reg <= (flen_reg != frr_pkg::LEN_W'(1));
                                end
                            end
                            else if (wleft_reg != '0 && wdrop_reg)
                            begin
                                wleft_reg <= wleft_reg - 1'b1;
                                if (wleft_reg == frr_pkg::LEN_W'(1))
                                begin
                                    wdrop_reg <= 1'b0;
                                end
                            end
                        end
                        else if (!rd_out && func_reg != frr_pkg::FN_READ)
                        begin
                            active_reg[idx_reg] <= (func_reg == frr_pkg::FN_ATTACH);
                            tail_reg[idx_reg]   <= head_reg;
                            cursor_reg[idx_reg] <= head_reg;
                            rleft_reg[idx_reg]  <= '0;
                            rlen_reg[idx_reg]   <= '0;
                        end
                    end
                    frr_pkg::S_W_SCAN:
                    begin
                        if (active_reg[idx_reg] && alu_y > worst_reg)
                        begin
                            worst_reg <= alu_y;
                        end
                        scan_reg <= RW'(scan_reg + 1'b1);
                        idx_reg  <= IW'(scan_reg + 1'b1);
                    end
                    frr_pkg::S_W_CHECK:
                    begin
                        k_reg <= '0;
                        if (drop_now)
                        begin
                            wleft_reg <= flen_reg - 1'b1;
                            wdrop_reg <= (flen_reg != frr_pkg::LEN_W'(1));
                        end
                    end
                    frr_pkg::S_W_HDR:
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    frr_pkg::S_W_POS:
                    begin
                        wpos_reg  <= alu_y;
                        wleft_reg <= flen_reg;
                    end
                    frr_pkg::S_W_DATA:
                    begin
                        wpos_reg  <= alu_y;
                        wleft_reg <= wleft_reg - 1'b1;
                        // last byte commits the frame to readers
                        if (wleft_reg == frr_pkg::LEN_W'(1))
                        begin
                            head_reg <= alu_y;
                        end
                    end
                    frr_pkg::S_R_USED:
                    begin
                        k_reg <= '0;
                    end
                    frr_pkg::S_R_HDATA:
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    frr_pkg::S_R_CUR4:
                    begin
                        cursor_reg[idx_reg] <= alu_y;
                        rleft_reg[idx_reg]  <= frr_pkg::LEN_W'(hl_reg);
                        rlen_reg[idx_reg]   <= frr_pkg::LEN_W'(hl_reg);
                    end
                    frr_pkg::S_R_BDATA:
                    begin
                        cursor_reg[idx_reg] <= alu_y;
                        rleft_reg[idx_reg]  <= rleft_reg[idx_reg] - 1'b1;
                        if (rleft_reg[idx_reg] == frr_pkg::LEN_W'(1))
                        begin
                            tail_reg[idx_reg] <= alu_y;
                        end
                    end
                    default:
                    begin
                        k_reg <= k_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            frr_pkg::S_IDLE:
            begin
                func_reg  <= frr_pkg::func_t'(cmd.func);
                id_reg    <= cmd.reader_id;
                wb_reg    <= cmd.write_byte;
                start_reg <= cmd.frame_start;
                flen_reg  <= cmd.frame_bytes;
                st_reg    <= frr_pkg::STAT_OK;
                rb_reg    <= '0;
                fe_reg    <= 1'b0;
                dl_reg    <= '0;
                hl_reg    <= '0;
            end
            frr_pkg::S_DISPATCH:
            begin
                y_reg <= YW'(flen_reg) + YW'(frr_pkg::HDR_BYTES + ALIGN_BYTES - 1);
                if (func_reg == frr_pkg::FN_WRITE)
                begin
                    if (start_reg)
                    begin
                        if (flen_reg == '0)
                        begin
                            st_reg <= frr_pkg::STAT_BAD_LEN;
                        end
                        else if (32'(flen_reg) > 32'(cap_reg))
                        begin
                            st_reg <= frr_pkg::STAT_NO_SPACE;
                        end
                    end
                    else if (wleft_reg == '0)
                    begin
                        st_reg <= frr_pkg::STAT_IGNORED;
                    end
                    else if (wdrop_reg)
                    begin
                        st_reg <= frr_pkg::STAT_NO_SPACE;
                    end
                end
                else if (rd_out)
                begin
                    st_reg <= (func_reg == frr_pkg::FN_READ) ? frr_pkg::STAT_INACTIVE
                                                             : frr_pkg::STAT_IGNORED;
                end
                else if (func_reg == frr_pkg::FN_READ && !active_reg[idx_reg])
                begin
                    st_reg <= frr_pkg::STAT_INACTIVE;
                end
            end
            frr_pkg::S_W_ALIGN1:
            begin
                prod_reg <= PRW'(y_reg) * PRW'(AMUL);
            end
            frr_pkg::S_W_ALIGN2:
            begin
                // round-up to alignment: floor(y / ALIGN) * ALIGN
                need_reg <= NW'(NW'(prod_reg[ASH +: YW]) * NW'(ALIGN_BYTES));
            end
            frr_pkg::S_W_CHECK:
            begin
                if (drop_now)
                begin
                    st_reg <= frr_pkg::STAT_NO_SPACE;
                end
            end
            frr_pkg::S_R_USED:
            begin
                ulen_reg <= alu_y;
                if (32'(alu_y) < 32'(frr_pkg::HDR_BYTES))
                begin
                    st_reg <= frr_pkg::STAT_EMPTY;
                end
            end
            frr_pkg::S_R_HDATA:
            begin
                hl_reg[8*k_reg +: 8] <= mem_rdata;
            end
            frr_pkg::S_R_HCHECK:
            begin
                if (hdr_bad)
                begin
                    st_reg <= frr_pkg::STAT_BAD_LEN;
                end
                else if (hdr_short)
                begin
                    st_reg <= frr_pkg::STAT_EMPTY;
                end
            end
            frr_pkg::S_R_BDATA:
            begin
                rb_reg <= mem_rdata;
                dl_reg <= rlen_reg[idx_reg];
                fe_reg <= (rleft_reg[idx_reg] == frr_pkg::LEN_W'(1));
            end
            frr_pkg::S_RESP:
            begin
                if (resp_load)
                begin
                    ost_reg <= st_reg;
                    orb_reg <= rb_reg;
                    ofe_reg <= fe_reg;
                    odl_reg <= dl_reg;
                end
            end
            default:
            begin
                y_reg <= y_reg;
            end
        endcase
    end

endmodule
